@@ hdl/ubxr_pkg.sv @@
// Shared types and constants of the UBX frame receiver.
// Used by ubxr_parser and ubx_frame_receiver_core.
`default_nettype none

package ubxr_pkg;

  typedef enum logic [3:0] {
    PH_HUNT  = 4'd0,
    PH_SYNC1 = 4'd1,
    PH_SYNC2 = 4'd2,
    PH_CLASS = 4'd3,
    PH_IDENT = 4'd4,
    PH_LEN1  = 4'd5,
    PH_DATA  = 4'd6,
    PH_CKA   = 4'd7,
    PH_CKB   = 4'd8
  } phase_t;

  typedef enum logic [1:0] {
    FUNC_BYTE    = 2'd0,
    FUNC_RELEASE = 2'd1,
    FUNC_READ    = 2'd2,
    FUNC_NONE    = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_SYNC     = 3'd1,
    ERR_OVERRUN  = 3'd2,
    ERR_LENGTH   = 3'd3,
    ERR_CHECK_A  = 3'd4,
    ERR_CHECK_B  = 3'd5
  } err_t;

  localparam logic CFG_SYNC_FIRST  = 1'b0;
  localparam logic CFG_SYNC_SECOND = 1'b1;

  localparam logic [7:0] SYNC_FIRST_RESET  = 8'd181;
  localparam logic [7:0] SYNC_SECOND_RESET = 8'd98;

  // Command from the input register to the parser
  typedef struct packed {
    logic       step;
    func_t      func;
    logic [7:0] data;
  } parse_cmd_t;

  // Result of one item, values as they stand after the item
  typedef struct packed {
    logic       done;
    err_t       err;
    logic [7:0] msg_class;
    logic [7:0] msg_ident;
    logic [7:0] msg_length;
    logic [7:0] dropped;
    logic       pending;
  } parse_res_t;

endpackage

`default_nettype wire

@@ hdl/ubxr_payload_buf.sv @@
// Payload byte buffer of the UBX frame receiver: one write port, one
// registered read port. Depends on nothing else.
`default_nettype none

module ubxr_payload_buf #(
  parameter int DEPTH = 255,
  parameter int AW    = 8
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire logic [7:0]    wr_data,
  input  wire logic          rd_en,
  input  wire logic [AW-1:0] rd_addr,
  output logic      [7:0]    rd_data
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ hdl/ubxr_parser.sv @@
// Frame parser state of the UBX frame receiver: phase, Fletcher sums,
// header fields, pending flag and overrun count. Uses ubxr_pkg.
`default_nettype none

module ubxr_parser #(
  parameter int MAX_PAYLOAD = 255,
  parameter int AW          = 8,
  parameter int PW          = 8
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [7:0]          sync_first,
  input  wire logic [7:0]          sync_second,
  input  wire ubxr_pkg::parse_cmd_t cmd,
  output ubxr_pkg::parse_res_t     res,
  output logic                     wr_en,
  output logic [AW-1:0]            wr_addr,
  output logic [7:0]               wr_data
);

  ubxr_pkg::phase_t phase, phase_next;
  logic [7:0]    sum_a, sum_a_next;
  logic [7:0]    sum_b, sum_b_next;
  logic [7:0]    frame_class, frame_class_next;
  logic [7:0]    frame_ident, frame_ident_next;
  logic [15:0]   frame_length, frame_length_next;
  logic [PW-1:0] position, position_next;
  logic          pending, pending_next;
  logic [7:0]    dropped, dropped_next;

  logic [7:0]    acc_a;
  logic [7:0]    acc_b;
  logic [15:0]   length_full;
  ubxr_pkg::err_t err;
  logic          done;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= ubxr_pkg::PH_HUNT;
      sum_a        <= '0;
      sum_b        <= '0;
      frame_class  <= '0;
      frame_ident  <= '0;
      frame_length <= '0;
      position     <= '0;
      pending      <= 1'b0;
      dropped      <= '0;
    end else begin
      phase        <= phase_next;
      sum_a        <= sum_a_next;
      sum_b        <= sum_b_next;
      frame_class  <= frame_class_next;
      frame_ident  <= frame_ident_next;
      frame_length <= frame_length_next;
      position     <= position_next;
      pending      <= pending_next;
      dropped      <= dropped_next;
    end
  end

  always_comb begin
    phase_next        = phase;
    sum_a_next        = sum_a;
    sum_b_next        = sum_b;
    frame_class_next  = frame_class;
    frame_ident_next  = frame_ident;
    frame_length_next = frame_length;
    position_next     = position;
    pending_next      = pending;
    dropped_next      = dropped;
    err               = ubxr_pkg::ERR_NONE;
    done              = 1'b0;
    wr_en             = 1'b0;
    wr_addr           = position[AW-1:0];
    wr_data           = cmd.data;
    acc_a             = sum_a + cmd.data;
    acc_b             = sum_b + acc_a;
    length_full       = {cmd.data, frame_length[7:0]};

    if (cmd.step && cmd.func == ubxr_pkg::FUNC_BYTE) begin
      // checksum covers class through payload
      if (phase inside {ubxr_pkg::PH_SYNC2, ubxr_pkg::PH_CLASS, ubxr_pkg::PH_IDENT,
                        ubxr_pkg::PH_LEN1, ubxr_pkg::PH_DATA}) begin
        sum_a_next = acc_a;
        sum_b_next = acc_b;
      end
      unique case (phase)
        ubxr_pkg::PH_HUNT: begin
          if (cmd.data == sync_first) phase_next = ubxr_pkg::PH_SYNC1;
        end
        ubxr_pkg::PH_SYNC1: begin
          if (cmd.data != sync_second) begin
            err = ubxr_pkg::ERR_SYNC;
          end else begin
            sum_a_next = '0;
            sum_b_next = '0;
            phase_next = ubxr_pkg::PH_SYNC2;
          end
        end
        ubxr_pkg::PH_SYNC2: begin
          if (pending) begin
            dropped_next = dropped + 8'd1;
            err          = ubxr_pkg::ERR_OVERRUN;
          end else begin
            frame_class_next = cmd.data;
            phase_next       = ubxr_pkg::PH_CLASS;
          end
        end
        ubxr_pkg::PH_CLASS: begin
          frame_ident_next = cmd.data;
          phase_next       = ubxr_pkg::PH_IDENT;
        end
        ubxr_pkg::PH_IDENT: begin
          frame_length_next = {8'd0, cmd.data};
          phase_next        = ubxr_pkg::PH_LEN1;
        end
        ubxr_pkg::PH_LEN1: begin
          frame_length_next = length_full;
          if (length_full > 16'(MAX_PAYLOAD)) begin
            err = ubxr_pkg::ERR_LENGTH;
          end else begin
            position_next = '0;
            // zero length skips straight to the checksum
            phase_next = (length_full == 16'd0) ? ubxr_pkg::PH_CKA : ubxr_pkg::PH_DATA;
          end
        end
        ubxr_pkg::PH_DATA: begin
          wr_en         = (32'(position) < MAX_PAYLOAD);
          position_next = position + PW'(1);
          if (16'(position_next) >= frame_length) phase_next = ubxr_pkg::PH_CKA;
        end
        ubxr_pkg::PH_CKA: begin
          if (cmd.data != sum_a) err = ubxr_pkg::ERR_CHECK_A;
          else phase_next = ubxr_pkg::PH_CKB;
        end
        ubxr_pkg::PH_CKB: begin
          if (cmd.data != sum_b) begin
            err = ubxr_pkg::ERR_CHECK_B;
          end else begin
            pending_next = 1'b1;
            done         = 1'b1;
            phase_next   = ubxr_pkg::PH_HUNT;
          end
        end
        default: phase_next = ubxr_pkg::PH_HUNT;
      endcase
      if (err != ubxr_pkg::ERR_NONE) phase_next = ubxr_pkg::PH_HUNT;
    end else if (cmd.step && cmd.func == ubxr_pkg::FUNC_RELEASE) begin
      pending_next = 1'b0;
    end

    res.done       = done;
    res.err        = err;
    res.msg_class  = frame_class_next;
    res.msg_ident  = frame_ident_next;
    res.msg_length = frame_length_next[7:0];
    res.dropped    = dropped_next;
    res.pending    = pending_next;
  end

endmodule

`default_nettype wire

@@ hdl/ubx_frame_receiver_core.sv @@
// Top level of the UBX frame receiver: input register, result register,
// parser and payload buffer. Uses ubxr_pkg, ubxr_parser, ubxr_payload_buf.
`default_nettype none

// Finds UBX binary frames in a stream of link bytes (sync, sync, class, id,
// 16-bit little-endian length, payload, Fletcher-8 checksum A and B) and
// keeps the payload in a buffer of MAX_PAYLOAD bytes. One item is accepted
// every cycle while in_stall is low. An accepted item waits in the input
// register and moves to the result register once that register is free,
// where the frame state is updated and the buffer read port is sampled. A
// stalled result holds the input register, which then stalls new items.
// Each item gives exactly one result. The buffer is not cleared after
// reset: reading a position that no frame has written returns an undefined
// byte. Sync byte values are set through the write port (index 0 first
// sync, 1 second sync).
module ubx_frame_receiver_core #(
  parameter int MAX_PAYLOAD = 255
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_we,
  input  wire logic       cfg_index,
  input  wire logic [7:0] cfg_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] func,
  input  wire logic [7:0] data_byte,
  input  wire logic [7:0] read_index,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            frame_done,
  output logic [2:0]      error_code,
  output logic [7:0]      msg_class,
  output logic [7:0]      msg_ident,
  output logic [7:0]      msg_length,
  output logic [7:0]      read_data,
  output logic [7:0]      overrun_count,
  output logic            frame_pending
);

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int PW = $clog2(MAX_PAYLOAD + 1);

  logic [7:0] sync_first;
  logic [7:0] sync_second;

  logic       in_full;
  logic [1:0] in_func;
  logic [7:0] in_data;
  logic [7:0] in_idx;
  logic       load;
  logic       read_hit;
  logic [15:0] idx_wide;

  ubxr_pkg::parse_cmd_t cmd;
  ubxr_pkg::parse_res_t res;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;
  logic [7:0]    buf_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      sync_first  <= ubxr_pkg::SYNC_FIRST_RESET;
      sync_second <= ubxr_pkg::SYNC_SECOND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ubxr_pkg::CFG_SYNC_FIRST:  sync_first  <= cfg_data;
        ubxr_pkg::CFG_SYNC_SECOND: sync_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // Advance an item into the result register when that register is free
  assign load     = in_full && (!out_valid || !out_stall);
  assign in_stall = in_full && !load;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_valid && !in_stall) begin
      in_full <= 1'b1;
    end else if (load) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      in_func <= func;
      in_data <= data_byte;
      in_idx  <= read_index;
    end
  end

  assign cmd.step = load;
  assign cmd.func = ubxr_pkg::func_t'(in_func);
  assign cmd.data = in_data;
  assign idx_wide = 16'(in_idx);

  ubxr_parser #(
    .MAX_PAYLOAD (MAX_PAYLOAD),
    .AW          (AW),
    .PW          (PW)
  ) u_parser (
    .clk         (clk),
    .rst         (rst),
    .sync_first  (sync_first),
    .sync_second (sync_second),
    .cmd         (cmd),
    .res         (res),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  ubxr_payload_buf #(
    .DEPTH (MAX_PAYLOAD),
    .AW    (AW)
  ) u_buf (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (load),
    .rd_addr (idx_wide[AW-1:0]),
    .rd_data (buf_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      frame_done    <= res.done;
      error_code    <= res.err;
      msg_class     <= res.msg_class;
      msg_ident     <= res.msg_ident;
      msg_length    <= res.msg_length;
      overrun_count <= res.dropped;
      frame_pending <= res.pending;
      read_hit      <= (in_func == ubxr_pkg::FUNC_READ) && (idx_wide < 16'(MAX_PAYLOAD));
    end
  end

  assign read_data = read_hit ? buf_q : 8'd0;

endmodule

`default_nettype wire
